// File: design/rkxhc_pkg.sv
// Shared package for the repeating-key XOR hex codec: beat types, register
// map, command codes and the hex character helpers. No dependencies.
`default_nettype none

package rkxhc_pkg;

   // key store
   localparam int KEY_BYTES  = 32;
   localparam int KEY_POS_W  = 5;
   localparam int KEY_WORDS  = 4;
   localparam int KEY_WORD_W = 64;
   localparam int KEY_BITS   = KEY_WORDS * KEY_WORD_W;
   localparam int KEY_LEN_W  = 6;

   // configuration port
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_IDX_W  = 3;

   localparam logic [CSR_IDX_W-1:0] REG_MODE       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_LENGTH = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_WORD_0 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_WORD_1 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_WORD_2 = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_WORD_3 = 3'd5;

   localparam logic MODE_ENCRYPT = 1'b0;
   localparam logic MODE_DECRYPT = 1'b1;

   // command kinds passed from front to back
   localparam logic CMD_HEX_PAIR = 1'b0;
   localparam logic CMD_BYTE     = 1'b1;

   // command queue depth
   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_in;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
   } rsp_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] value;
      logic       last;
   } cmd_type;

   typedef struct packed {
      logic                 mode;
      logic [KEY_LEN_W-1:0] key_length;
      logic [KEY_BITS-1:0]  key;
   } cfg_type;

   // nibble to uppercase ASCII hex
   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] wide;
      wide = {4'd0, nib};
      if (nib > 4'd9) begin
         hex_char = (wide - 8'd9) | 8'h40;
      end else begin
         hex_char = wide | 8'h30;
      end
   endfunction

   // character to nibble: letters (bit 6 set) get +9, no validity check
   function automatic logic [3:0] char_nibble(input logic [7:0] c);
      if (c[6]) begin
         char_nibble = c[3:0] + 4'd9;
      end else begin
         char_nibble = c[3:0];
      end
   endfunction

endpackage

`default_nettype wire

// File: design/repeating_key_xor_hex_codec_core.sv
// Top level of the repeating-key XOR hex codec: register file, front,
// command queue and back. Depends on rkxhc_pkg, rkxhc_front, rkxhc_fifo, rkxhc_back.
//
//   channel   ports                          accepted when
//   req       req_push req_full req_data     req_push && !req_full
//   rsp       rsp_empty rsp_pop rsp_data     rsp_pop && !rsp_empty
//   csr       csr_psel .. csr_prdata         psel && penable && pwrite (pready = 1)
//
// Encrypt: each byte yields two hex characters through the back's output register, which
// gives one beat per cycle while rsp is not stalled; decrypt: a character pair yields one byte.
// A result beat passes through the command queue and then the back's output register.
// Reset is synchronous and clears queue pointers, output valid flag, sequence state and
// registers at once. A stalled rsp side fills the 4-entry queue, then req_full rises.
`default_nettype none

module repeating_key_xor_hex_codec_core (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_push,
   output logic                                      req_full,
   input  wire rkxhc_pkg::req_type                   req_data,
   output logic                                      rsp_empty,
   input  wire logic                                 rsp_pop,
   output rkxhc_pkg::rsp_type                        rsp_data,
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [rkxhc_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [rkxhc_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [rkxhc_pkg::CSR_DATA_W-1:0]          csr_prdata,
   output logic                                      csr_pready
);
   import rkxhc_pkg::*;

   logic                  mode_ff;
   logic [KEY_LEN_W-1:0]  key_length_ff;
   logic [KEY_WORD_W-1:0] key_word_ff [KEY_WORDS];
   logic [CSR_IDX_W-1:0]  csr_idx;
   logic                  csr_write;
   cfg_type               cfg;

   logic    q_full, q_empty, q_push, q_pop, accept;
   cmd_type q_entry, q_head;

   // register write decode
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:3];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_ENCRYPT;
         key_length_ff <= KEY_LEN_W'(1);
         for (int i = 0; i < KEY_WORDS; i++) begin
            key_word_ff[i] <= '0;
         end
      end else if (csr_write) begin
         unique case (csr_idx)
            REG_MODE:       mode_ff        <= csr_pwdata[0];
            REG_KEY_LENGTH: key_length_ff  <= csr_pwdata[KEY_LEN_W-1:0];
            REG_KEY_WORD_0: key_word_ff[0] <= csr_pwdata;
            REG_KEY_WORD_1: key_word_ff[1] <= csr_pwdata;
            REG_KEY_WORD_2: key_word_ff[2] <= csr_pwdata;
            REG_KEY_WORD_3: key_word_ff[3] <= csr_pwdata;
            default:        ;
         endcase
      end
   end

   // register read mux
   always_comb begin
      unique case (csr_idx)
         REG_MODE:       csr_prdata = {{(CSR_DATA_W-1){1'b0}}, mode_ff};
         REG_KEY_LENGTH: csr_prdata = {{(CSR_DATA_W-KEY_LEN_W){1'b0}}, key_length_ff};
         REG_KEY_WORD_0: csr_prdata = key_word_ff[0];
         REG_KEY_WORD_1: csr_prdata = key_word_ff[1];
         REG_KEY_WORD_2: csr_prdata = key_word_ff[2];
         REG_KEY_WORD_3: csr_prdata = key_word_ff[3];
         default:        csr_prdata = '0;
      endcase
   end

   assign cfg = '{mode: mode_ff, key_length: key_length_ff,
                  key: {key_word_ff[3], key_word_ff[2], key_word_ff[1], key_word_ff[0]}};

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   rkxhc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .accept   (accept),
      .req_data (req_data),
      .q_push   (q_push),
      .q_entry  (q_entry)
   );

   rkxhc_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head       (q_head),
      .empty      (q_empty)
   );

   rkxhc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// File: design/rkxhc_front.sv
// Front of the codec: accepts input beats, tracks key position and held
// nibble, and issues commands to the queue. Depends on rkxhc_pkg.
`default_nettype none

module rkxhc_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire rkxhc_pkg::cfg_type cfg,
   input  wire logic              accept,
   input  wire rkxhc_pkg::req_type req_data,
   output logic                   q_push,
   output rkxhc_pkg::cmd_type     q_entry
);
   import rkxhc_pkg::*;

   logic [KEY_POS_W-1:0] key_pos_ff, key_pos_in;
   logic                 half_ff, half_in;
   logic [3:0]           held_ff, held_in;

   logic [KEY_LEN_W-1:0] eff_len;
   logic [KEY_LEN_W-1:0] next_pos;
   logic [KEY_POS_W-1:0] adv_pos;
   logic [7:0]           key_byte;
   logic [3:0]           nib;

   // effective key length clamped to 1..KEY_BYTES
   always_comb begin
      if (cfg.key_length == '0) begin
         eff_len = KEY_LEN_W'(1);
      end else if (cfg.key_length > KEY_LEN_W'(KEY_BYTES)) begin
         eff_len = KEY_LEN_W'(KEY_BYTES);
      end else begin
         eff_len = cfg.key_length;
      end
   end

   // key byte at current position and wrapped next position
   assign key_byte = cfg.key[{key_pos_ff, 3'b000} +: 8];
   assign next_pos = {1'b0, key_pos_ff} + KEY_LEN_W'(1);
   assign adv_pos  = (next_pos >= eff_len) ? '0 : next_pos[KEY_POS_W-1:0];
   assign nib      = char_nibble(req_data.data_byte);

   // classify the beat and update the sequence state
   always_comb begin
      key_pos_in = key_pos_ff;
      half_in    = half_ff;
      held_in    = held_ff;
      q_push     = 1'b0;
      q_entry    = '{kind: CMD_BYTE, value: 8'd0, last: 1'b0};
      if (accept) begin
         if (cfg.mode == MODE_ENCRYPT) begin
            q_push     = 1'b1;
            q_entry    = '{kind: CMD_HEX_PAIR, value: req_data.data_byte ^ key_byte,
                           last: req_data.last_in};
            half_in    = 1'b0;
            held_in    = 4'd0;
            key_pos_in = req_data.last_in ? '0 : adv_pos;
         end else if (!half_ff) begin
            if (!req_data.last_in) begin
               half_in = 1'b1;
               held_in = nib;
            end else begin
               // odd final character: low nibble of zero
               q_push     = 1'b1;
               q_entry    = '{kind: CMD_BYTE, value: {nib, 4'd0} ^ key_byte, last: 1'b1};
               key_pos_in = '0;
               half_in    = 1'b0;
               held_in    = 4'd0;
            end
         end else begin
            q_push     = 1'b1;
            q_entry    = '{kind: CMD_BYTE, value: {held_ff, nib} ^ key_byte,
                           last: req_data.last_in};
            half_in    = 1'b0;
            held_in    = 4'd0;
            key_pos_in = req_data.last_in ? '0 : adv_pos;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_pos_ff <= '0;
         half_ff    <= 1'b0;
         held_ff    <= 4'd0;
      end else begin
         key_pos_ff <= key_pos_in;
         half_ff    <= half_in;
         held_ff    <= held_in;
      end
   end

endmodule

`default_nettype wire

// File: design/rkxhc_fifo.sv
// Short command queue between front and back of the codec.
// Depends on rkxhc_pkg for the command type and depth.
`default_nettype none

module rkxhc_fifo (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire rkxhc_pkg::cmd_type push_entry,
   output logic                   full,
   input  wire logic              pop,
   output rkxhc_pkg::cmd_type     head,
   output logic                   empty
);
   import rkxhc_pkg::*;

   cmd_type              entries_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff, count_in;
   logic                 do_push, do_pop;

   assign full    = (count_ff == Q_CNT_W'(Q_DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = entries_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + Q_PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + Q_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + Q_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - Q_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// File: design/rkxhc_back.sv
// Back of the codec: expands queued commands into result beats through an
// output register, two hex characters for a pair. Depends on rkxhc_pkg.
`default_nettype none

module rkxhc_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_empty,
   input  wire rkxhc_pkg::cmd_type q_head,
   output logic                   q_pop,
   input  wire logic              rsp_pop,
   output logic                   rsp_empty,
   output rkxhc_pkg::rsp_type     rsp_data
);
   import rkxhc_pkg::*;

   logic    valid_ff, valid_in;
   logic    phase_ff, phase_in;
   rsp_type data_ff, data_in;
   logic    load;

   // output register frees up when empty or its beat is taken
   assign load      = !q_empty && (!valid_ff || rsp_pop);
   assign rsp_empty = !valid_ff;
   assign rsp_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      phase_in = phase_ff;
      data_in  = data_ff;
      q_pop    = 1'b0;
      if (valid_ff && rsp_pop) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
         if (q_head.kind == CMD_HEX_PAIR && !phase_ff) begin
            // high nibble first, command stays at the queue head
            data_in  = '{out_byte: hex_char(q_head.value[7:4]), out_last: 1'b0};
            phase_in = 1'b1;
         end else if (q_head.kind == CMD_HEX_PAIR) begin
            data_in  = '{out_byte: hex_char(q_head.value[3:0]), out_last: q_head.last};
            phase_in = 1'b0;
            q_pop    = 1'b1;
         end else begin
            data_in  = '{out_byte: q_head.value, out_last: q_head.last};
            q_pop    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

`default_nettype wire

// File: design/rkxhc_checker.sv
// Port-level checker for the codec top level, attached by bind.
// Depends on rkxhc_pkg and repeating_key_xor_hex_codec_core.
`default_nettype none

module rkxhc_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_full,
   input wire logic                             rsp_empty,
   input wire logic                             rsp_pop,
   input wire rkxhc_pkg::rsp_type               rsp_data,
   input wire logic                             csr_psel,
   input wire logic                             csr_penable,
   input wire logic                             csr_pwrite,
   input wire logic [rkxhc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input wire logic [rkxhc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input wire logic [rkxhc_pkg::CSR_DATA_W-1:0] csr_prdata,
   input wire logic                             csr_pready
);
   import rkxhc_pkg::*;

   // nothing to deliver and room for beats right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> (rsp_empty && !req_full))
      else $error("result or full flag present after reset");

   // a waiting result beat holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("result beat changed while stalled");

   a_pready: assert property (@(posedge clock)
      csr_pready)
      else $error("pready dropped");

   // key length readback matches the written bits
   a_keylen_readback: assert property (@(posedge clock) disable iff (reset)
      (csr_psel && csr_penable && csr_pwrite && csr_paddr[CSR_ADDR_W-1:3] == REG_KEY_LENGTH)
      |=> (csr_paddr[CSR_ADDR_W-1:3] != REG_KEY_LENGTH ||
           csr_prdata[KEY_LEN_W-1:0] == $past(csr_pwdata[KEY_LEN_W-1:0])))
      else $error("key length readback mismatch");

endmodule

bind repeating_key_xor_hex_codec_core rkxhc_checker u_rkxhc_checker (.*);

`default_nettype wire

// File: test/repeating_key_xor_hex_codec_core_tb.sv
// Self-checking testbench for repeating_key_xor_hex_codec_core: random push/pop
// gaps, register writes between phases, and a bit-exact codec predictor.
// Depends on rkxhc_pkg and the core RTL only.

module repeating_key_xor_hex_codec_core_tb;
   import rkxhc_pkg::*;

   localparam int STALL_LIMIT  = 1000;
   localparam int DRAIN_CYCLES = 8;
   localparam int RANDOM_ITEMS = 800;
   // indexes past the register map; writes there must be dropped
   localparam logic [CSR_IDX_W-1:0] REG_UNMAPPED    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_push = 1'b0;
   logic                  req_full;
   req_type               req_data = '0;
   logic                  rsp_empty;
   logic                  rsp_pop = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   repeating_key_xor_hex_codec_core dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // shadow registers and sequence state of the codec
   logic                  cfg_mode = MODE_ENCRYPT;
   logic [KEY_LEN_W-1:0]  cfg_key_len = 6'd1;
   logic [KEY_WORD_W-1:0] cfg_key [KEY_WORDS] = '{default: '0};
   logic [KEY_POS_W-1:0]  key_pos = '0;
   logic                  nibble_held = 1'b0;
   logic [3:0]            held_nibble = '0;

   req_type item_q [$];
   rsp_type expected_rsp_q [$];
   int      items_left = 0;
   int      error_count = 0;
   int      cycle_count = 0;
   int      last_beat_cycle = 0;
   int      push_gap = 0;
   int      pop_gap = 0;
   bit      steady_flow = 1'b0;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // mostly short gaps, a few long ones, none during steady stretches
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady_flow || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(6, 24);
   endfunction

   function automatic logic [7:0] nibble_to_hex(input logic [3:0] nib);
      return (nib > 4'd9) ? 8'("A") + 8'(nib) - 8'd10 : 8'("0") + 8'(nib);
   endfunction

   // letters (bit 6 set) map to their low nibble plus 9, everything else to its low nibble
   function automatic logic [3:0] hex_to_nibble(input logic [7:0] c);
      return c[6] ? c[3:0] + 4'd9 : c[3:0];
   endfunction

   function automatic void advance_key_pos();
      logic [5:0] span;
      logic [5:0] nxt;
      span = (cfg_key_len == 0) ? 6'd1 : (cfg_key_len > KEY_BYTES) ? 6'(KEY_BYTES) : cfg_key_len;
      nxt = {1'b0, key_pos} + 6'd1;
      key_pos = (nxt >= span) ? '0 : nxt[KEY_POS_W-1:0];
   endfunction

   // computes the result beats one accepted input beat causes
   function automatic void codec_step(input req_type it);
      logic [7:0] kb;
      logic [7:0] b;
      logic [3:0] nib;
      kb = cfg_key[key_pos[4:3]][8*key_pos[2:0] +: 8];
      if (cfg_mode == MODE_ENCRYPT) begin
         b = it.data_byte ^ kb;
         expected_rsp_q.push_back('{out_byte: nibble_to_hex(b[7:4]), out_last: 1'b0});
         expected_rsp_q.push_back('{out_byte: nibble_to_hex(b[3:0]), out_last: it.last_in});
         nibble_held = 1'b0;
         held_nibble = '0;
         advance_key_pos();
         if (it.last_in) key_pos = '0;
      end else if (!nibble_held) begin
         nib = hex_to_nibble(it.data_byte);
         if (!it.last_in) begin
            held_nibble = nib;
            nibble_held = 1'b1;
         end else begin
            // odd final character: low nibble is zero
            expected_rsp_q.push_back('{out_byte: {nib, 4'h0} ^ kb, out_last: 1'b1});
            key_pos = '0;
         end
      end else begin
         b = {held_nibble, hex_to_nibble(it.data_byte)} ^ kb;
         expected_rsp_q.push_back('{out_byte: b, out_last: it.last_in});
         advance_key_pos();
         nibble_held = 1'b0;
         held_nibble = '0;
         if (it.last_in) key_pos = '0;
      end
   endfunction

   // request driver: holds a beat until accepted, then maybe idles
   always @(posedge clock) begin : req_driver
      if (reset) begin
         req_push <= 1'b0;
         push_gap = 0;
      end else begin
         if (req_push && !req_full) begin
            codec_step(req_data);
            items_left--;
            last_beat_cycle = cycle_count;
            push_gap = pick_gap();
         end
         if (req_push && req_full) begin
            // stalled: keep the beat on the port
         end else if (push_gap > 0) begin
            push_gap--;
            req_push <= 1'b0;
         end else if (item_q.size() > 0) begin
            req_data <= item_q.pop_front();
            req_push <= 1'b1;
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // result monitor: random pop stalls, compares with oldest expectation
   always @(posedge clock) begin : rsp_monitor
      rsp_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
         pop_gap = 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            last_beat_cycle = cycle_count;
            if (expected_rsp_q.size() == 0) begin
               $display("%0t: unexpected beat: expected none, got byte %02h last %0b",
                        $time, rsp_data.out_byte, rsp_data.out_last);
               error_count++;
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_data.out_byte !== want.out_byte) begin
                  $display("%0t: out_byte expected %02h, got %02h",
                           $time, want.out_byte, rsp_data.out_byte);
                  error_count++;
               end
               if (rsp_data.out_last !== want.out_last) begin
                  $display("%0t: out_last expected %0b, got %0b",
                           $time, want.out_last, rsp_data.out_last);
                  error_count++;
               end
            end
            pop_gap = pick_gap();
         end
         if (pop_gap > 0) begin
            pop_gap--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      wait (cycle_count - last_beat_cycle > STALL_LIMIT);
      $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

   // setup cycle, access cycle; register updates at the access edge
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      last_beat_cycle = cycle_count;
      case (idx)
         REG_MODE:       cfg_mode = val[0];
         REG_KEY_LENGTH: cfg_key_len = val[KEY_LEN_W-1:0];
         REG_KEY_WORD_0: cfg_key[0] = val;
         REG_KEY_WORD_1: cfg_key[1] = val;
         REG_KEY_WORD_2: cfg_key[2] = val;
         REG_KEY_WORD_3: cfg_key[3] = val;
         default: ;
      endcase
   endtask

   task automatic queue_item(input logic [7:0] d, input logic last);
      item_q.push_back('{data_byte: d, last_in: last});
      items_left++;
   endtask

   // wait for all beats to drain, then let a held character settle
   task automatic finish_phase();
      while (items_left != 0 || expected_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_hex_char();
      int r;
      logic [3:0] nib;
      r = $urandom_range(0, 99);
      nib = 4'($urandom_range(0, 15));
      if (r < 15) return 8'($urandom_range(0, 255));
      if (r < 35 && nib > 4'd9) return 8'("a") + 8'(nib) - 8'd10;
      return nibble_to_hex(nib);
   endfunction

   function automatic logic [KEY_WORD_W-1:0] pick_key_word();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   initial begin : stimulus
      int queued;
      int len;
      bit ends;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset settings: encrypt, one zero key byte
      queue_item(8'h00, 1'b0);
      queue_item(8'hFF, 1'b1);
      finish_phase();

      // key length zero acts as one
      csr_write(REG_KEY_WORD_0, 64'h0123_4567_89AB_CDEF);
      csr_write(REG_KEY_WORD_1, '1);
      csr_write(REG_KEY_WORD_2, {$urandom, $urandom});
      csr_write(REG_KEY_WORD_3, {$urandom, $urandom});
      csr_write(REG_KEY_LENGTH, 64'd0);
      csr_write(REG_UNMAPPED, '1);
      queue_item(8'hA5, 1'b0);
      queue_item(8'h5A, 1'b1);
      finish_phase();

      // decrypt with length clamped to 32: digits, letters, lowercase, junk
      csr_write(REG_KEY_LENGTH, 64'd63);
      csr_write(REG_MODE, 64'(MODE_DECRYPT));
      queue_item("0", 1'b0);
      queue_item("9", 1'b0);
      queue_item("A", 1'b0);
      queue_item("F", 1'b0);
      queue_item("a", 1'b0);
      queue_item("f", 1'b1);
      queue_item("F", 1'b1);
      queue_item(8'h00, 1'b0);
      queue_item(8'hFF, 1'b1);
      finish_phase();

      // mode change with a nibble held: encrypt drops it
      queue_item("7", 1'b0);
      finish_phase();
      csr_write(REG_MODE, 64'(MODE_ENCRYPT));
      queue_item(8'h3C, 1'b1);
      finish_phase();

      // key length lowered below the current position mid-message
      csr_write(REG_KEY_LENGTH, 64'd5);
      queue_item(8'h11, 1'b0);
      queue_item(8'h22, 1'b0);
      queue_item(8'h33, 1'b0);
      finish_phase();
      csr_write(REG_KEY_LENGTH, 64'd2);
      queue_item(8'h44, 1'b0);
      queue_item(8'h55, 1'b0);
      queue_item(8'h66, 1'b1);
      finish_phase();

      // random phases, each with fresh settings
      queued = 0;
      while (queued < RANDOM_ITEMS) begin
         csr_write(REG_MODE, 64'($urandom_range(0, 1)));
         case ($urandom_range(0, 7))
            0:       csr_write(REG_KEY_LENGTH, 64'd1);
            1:       csr_write(REG_KEY_LENGTH, 64'd32);
            2:       csr_write(REG_KEY_LENGTH, 64'($urandom_range(0, 1) ? 0 : $urandom_range(33, 63)));
            default: csr_write(REG_KEY_LENGTH, 64'($urandom_range(1, 32)));
         endcase
         for (int w = 0; w < KEY_WORDS; w++) begin
            if ($urandom_range(0, 1)) csr_write(CSR_IDX_W'(REG_KEY_WORD_0 + w), pick_key_word());
         end
         if ($urandom_range(0, 9) == 0) csr_write(REG_UNMAPPED_HI, {$urandom, $urandom});
         steady_flow = ($urandom_range(0, 4) == 0);
         len = 0;
         while (len < $urandom_range(10, 60)) begin
            int msg_len;
            msg_len = $urandom_range(1, 10);
            // decrypt messages are mostly whole character pairs
            if (cfg_mode == MODE_DECRYPT && $urandom_range(0, 4) != 0) msg_len = 2 * msg_len;
            ends = ($urandom_range(0, 9) != 0);
            for (int i = 0; i < msg_len; i++) begin
               queue_item(cfg_mode == MODE_DECRYPT ? pick_hex_char() : 8'($urandom),
                          ends && i == msg_len - 1);
            end
            len += msg_len;
         end
         queued += len;
         finish_phase();
         steady_flow = 1'b0;
      end

      finish_phase();
      if (expected_rsp_q.size() != 0) begin
         $display("%0t: %0d result beats never arrived", $time, expected_rsp_q.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
